### sv/gsa_pkg.sv
`default_nettype none
package gsa_pkg;

  localparam int SLOT_COUNT   = 1024;
  localparam int IDX_W        = $clog2(SLOT_COUNT);
  localparam int CNT_W        = IDX_W + 1;
  localparam int SLOT_FIELD_W = 10;
  localparam int ID_W         = 32;
  localparam int GEN_W        = 32;
  localparam int REV_W        = 64;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DEAD = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // one slot record
  typedef struct packed {
    logic             alive;
    logic [GEN_W-1:0] gen;
    logic [REV_W-1:0] rev;
  } rec_t;

  // free stack entry carries the generation the slot will be reused with
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] slot;
  } stk_t;

endpackage
`default_nettype wire

### sv/generational_slot_allocator.sv
`default_nettype none
// Handle table with generations. Each operation word (create, destroy, query,
// advance) gives exactly one result word. An accepted word first reads the
// slot record and the top of the free stack out of their synchronous
// memories; in S_EXEC the block checks the handle, writes the record back
// and loads the result register, and only then raises in_ready again, so it
// takes no new word while one is in flight. A result that is not taken holds
// the next word in S_EXEC. Slot records and the free stack are not cleared
// after reset: a slot's record is only used below the count of slots ever
// handed out. The user must write own_registry_id (own_id) by cfg_we/cfg_data
// only while no word is in flight; the block itself does not enforce this.
module generational_slot_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [gsa_pkg::ID_W-1:0]          cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        op,
  input  wire logic [gsa_pkg::ID_W-1:0]          handle_registry,
  input  wire logic [gsa_pkg::SLOT_FIELD_W-1:0]  handle_slot,
  input  wire logic [gsa_pkg::GEN_W-1:0]         handle_generation,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             status,
  output logic [gsa_pkg::ID_W-1:0]               out_registry,
  output logic [gsa_pkg::SLOT_FIELD_W-1:0]       out_slot,
  output logic [gsa_pkg::GEN_W-1:0]              out_generation,
  output logic [gsa_pkg::REV_W-1:0]              out_revision
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                           state;
  logic [gsa_pkg::ID_W-1:0]         own_id;
  logic [gsa_pkg::CNT_W-1:0]        free_count, free_count_next;
  logic [gsa_pkg::CNT_W-1:0]        high_water, high_water_next;

  gsa_pkg::op_t                     op_q;
  logic [gsa_pkg::ID_W-1:0]         reg_q;
  logic [gsa_pkg::SLOT_FIELD_W-1:0] slot_q;
  logic [gsa_pkg::GEN_W-1:0]        gen_q;

  gsa_pkg::rec_t                    rec_mem [gsa_pkg::SLOT_COUNT];
  gsa_pkg::stk_t                    stk_mem [gsa_pkg::SLOT_COUNT];
  gsa_pkg::rec_t                    rec_rd;
  gsa_pkg::stk_t                    stk_rd;

  logic                             accept, fire;
  logic                             rec_we, stk_we;
  logic [gsa_pkg::IDX_W-1:0]        rec_waddr, stk_waddr;
  gsa_pkg::rec_t                    rec_wdata;
  gsa_pkg::stk_t                    stk_wdata;
  logic [gsa_pkg::CNT_W-1:0]        pop_addr;

  logic                             hit;
  logic [gsa_pkg::IDX_W-1:0]        new_slot;
  logic [gsa_pkg::GEN_W-1:0]        new_gen, bumped_gen;
  logic [gsa_pkg::REV_W-1:0]        bumped_rev;
  gsa_pkg::status_t                 res_status;
  logic [gsa_pkg::ID_W-1:0]         res_registry;
  logic [gsa_pkg::SLOT_FIELD_W-1:0] res_slot;
  logic [gsa_pkg::GEN_W-1:0]        res_gen;
  logic [gsa_pkg::REV_W-1:0]        res_rev;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state == S_EXEC) && (!out_valid || out_ready);
  assign pop_addr = free_count - gsa_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_rd <= rec_mem[gsa_pkg::IDX_W'(handle_slot)];
      stk_rd <= stk_mem[pop_addr[gsa_pkg::IDX_W-1:0]];
    end
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  // handle check and record update
  always_comb begin
    hit = (reg_q == own_id)
          && (32'(slot_q) < 32'(high_water))
          && rec_rd.alive && (rec_rd.gen == gen_q);
    bumped_gen = (rec_rd.gen == '1) ? gsa_pkg::GEN_W'(1) : rec_rd.gen + gsa_pkg::GEN_W'(1);
    bumped_rev = (rec_rd.rev == '1) ? gsa_pkg::REV_W'(1) : rec_rd.rev + gsa_pkg::REV_W'(1);

    free_count_next = free_count;
    high_water_next = high_water;
    rec_we          = 1'b0;
    stk_we          = 1'b0;
    rec_waddr       = gsa_pkg::IDX_W'(slot_q);
    stk_waddr       = free_count[gsa_pkg::IDX_W-1:0];
    rec_wdata       = rec_rd;
    stk_wdata       = '{gen: bumped_gen, slot: gsa_pkg::IDX_W'(slot_q)};
    new_slot        = stk_rd.slot;
    new_gen         = stk_rd.gen;
    res_status      = gsa_pkg::ST_OK;
    res_registry    = '0;
    res_slot        = '0;
    res_gen         = '0;
    res_rev         = '0;

    if (op_q == gsa_pkg::OP_CREATE) begin
      priority if (free_count != '0) begin
        free_count_next = pop_addr;
      end else if (high_water != gsa_pkg::CNT_W'(gsa_pkg::SLOT_COUNT)) begin
        new_slot        = high_water[gsa_pkg::IDX_W-1:0];
        new_gen         = gsa_pkg::GEN_W'(1);
        high_water_next = high_water + gsa_pkg::CNT_W'(1);
      end else begin
        res_status = gsa_pkg::ST_FULL;
      end
      if (res_status == gsa_pkg::ST_OK) begin
        rec_we       = fire;
        rec_waddr    = new_slot;
        rec_wdata    = '{alive: 1'b1, gen: new_gen, rev: gsa_pkg::REV_W'(1)};
        res_registry = own_id;
        res_slot     = gsa_pkg::SLOT_FIELD_W'(new_slot);
        res_gen      = new_gen;
        res_rev      = gsa_pkg::REV_W'(1);
      end
    end else if (!hit) begin
      res_status = gsa_pkg::ST_DEAD;
    end else begin
      unique case (op_q)
        gsa_pkg::OP_DESTROY: begin
          rec_we    = fire;
          rec_wdata = '{alive: 1'b0, gen: bumped_gen, rev: '0};
          if (free_count != gsa_pkg::CNT_W'(gsa_pkg::SLOT_COUNT)) begin
            stk_we          = fire;
            free_count_next = free_count + gsa_pkg::CNT_W'(1);
          end
        end
        gsa_pkg::OP_ADVANCE: begin
          rec_we        = fire;
          rec_wdata.rev = bumped_rev;
          res_rev       = bumped_rev;
        end
        default: begin
          res_rev = rec_rd.rev;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      own_id     <= gsa_pkg::ID_W'(1);
      free_count <= '0;
      high_water <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        own_id <= cfg_data;
      end
      if (out_valid && out_ready && !fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q   <= gsa_pkg::op_t'(op);
            reg_q  <= handle_registry;
            slot_q <= handle_slot;
            gen_q  <= handle_generation;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            free_count     <= free_count_next;
            high_water     <= high_water_next;
            out_valid      <= 1'b1;
            status         <= res_status;
            out_registry   <= res_registry;
            out_slot       <= res_slot;
            out_generation <= res_gen;
            out_revision   <= res_rev;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/gsa_checker.sv
`default_nettype none
module gsa_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [1:0]                        status,
  input wire logic [gsa_pkg::ID_W-1:0]          out_registry,
  input wire logic [gsa_pkg::GEN_W-1:0]         out_generation,
  input wire logic [gsa_pkg::REV_W-1:0]         out_revision
);

  // a stalled result word holds its status and revision
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_revision))
    else $error("result word changed while stalled");

  // a refused create carries nothing
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == gsa_pkg::ST_FULL |->
      out_registry == '0 && out_generation == '0 && out_revision == '0)
    else $error("full result carries data");

  // a dead handle carries nothing
  a_dead: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == gsa_pkg::ST_DEAD |->
      out_registry == '0 && out_generation == '0 && out_revision == '0)
    else $error("dead-handle result carries data");

  // only a create returns a generation, and a fresh slot starts at revision one
  a_create: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == gsa_pkg::ST_OK && out_generation != '0 |->
      out_revision == gsa_pkg::REV_W'(1))
    else $error("created handle without revision one");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .out_registry   (out_registry),
  .out_generation (out_generation),
  .out_revision   (out_revision)
);
`default_nettype wire
